/* rtl/i2cmbe_pkg.sv */
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the engine.
package i2cmbe_pkg;

  localparam int DATA_BITS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd10;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_SEND  = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // phase counts per command
  localparam logic [4:0] PH_START = 5'd3;
  localparam logic [4:0] PH_STOP  = 5'd1;
  localparam logic [4:0] PH_SEND  = 5'(3 * DATA_BITS);
  localparam logic [4:0] PH_WAIT  = 5'd3;
  localparam logic [4:0] PH_READ  = 5'(2 * DATA_BITS + 3);
  localparam logic [4:0] PH_RBITS = 5'(2 * DATA_BITS);

  localparam logic [3:0] LAST_BIT  = 4'(DATA_BITS - 1);
  localparam logic [3:0] BYTE_BITS = 4'(DATA_BITS);

  // one classified tick
  typedef struct packed {
    logic                 cmd_go;
    op_t                  op;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 send_ack;
    logic                 sda_in;
  } item_t;

  // queue -> back handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [4:0] total_phases(op_t op);
    logic [4:0] n;
    begin
      unique case (op)
        OP_START: n = PH_START;
        OP_STOP:  n = PH_STOP;
        OP_SEND:  n = PH_SEND;
        OP_WAIT:  n = PH_WAIT;
        default:  n = PH_READ;
      endcase
      return n;
    end
  endfunction

endpackage

/* rtl/i2c_master_bit_engine_core.sv */
// Top level of the I2C master bit engine: front classifier, tick queue, back sequencer.
// Depends on i2cmbe_pkg, i2cmbe_front, i2cmbe_queue, i2cmbe_back.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid / in_stall + fields   | one request per timing tick
//  out     | out_valid / out_stall + fields | one pin/status result per request
//  cfg     | cfg_wr_en / cfg_wr_data        | phase_ticks, write only
//
// One request per cycle sustained while out_stall is low; from accept to result
// each request passes a queue slot, then one sequencer update into the result register.
// The sequencer state update is the single-cycle loop that sets the rate.
// Reset (rst_n low, synchronous) idles the sequencer, releases SCL/SDA,
// empties the queue and loads phase_ticks with 10.
// in_stall rises only when the 2-entry queue is full; a stalled result
// holds since the sequencer advances only when the result register drains.
module i2c_master_bit_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd_valid,
  input  logic [2:0] in_opcode,
  input  logic [i2cmbe_pkg::DATA_BITS-1:0] in_tx_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [i2cmbe_pkg::DATA_BITS-1:0] out_rx_byte,
  output logic       out_ack_seen,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import i2cmbe_pkg::*;

  item_t     front_item;
  q_head_t   q_head;
  logic      q_full;
  logic      q_pop;
  logic [7:0] phase_ticks_r;

  // phase length register; zero behaves like one through the >= compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;

  i2cmbe_front u_front (
    .in_cmd_valid (in_cmd_valid),
    .in_opcode    (in_opcode),
    .in_tx_byte   (in_tx_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .item         (front_item)
  );

  // decouples request intake from the sequencer
  i2cmbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  i2cmbe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .phase_ticks  (phase_ticks_r),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_ack_seen (out_ack_seen)
  );

endmodule

/* rtl/i2cmbe_front.sv */
// Front end: qualifies the command on each incoming tick.
// Depends on i2cmbe_pkg.
module i2cmbe_front (
  input  logic                          in_cmd_valid,
  input  logic [2:0]                    in_opcode,
  input  logic [i2cmbe_pkg::DATA_BITS-1:0] in_tx_byte,
  input  logic                          in_send_ack,
  input  logic                          in_sda_in,
  output i2cmbe_pkg::item_t             item
);
  import i2cmbe_pkg::*;

  logic op_legal;

  // opcodes above read are dropped here
  assign op_legal = (in_opcode <= 3'(OP_READ));

  always_comb begin
    item.cmd_go   = in_cmd_valid & op_legal;
    item.op       = op_legal ? op_t'(in_opcode) : OP_START;
    item.tx_byte  = in_tx_byte;
    item.send_ack = in_send_ack;
    item.sda_in   = in_sda_in;
  end

endmodule

/* rtl/i2cmbe_queue.sv */
// Two-entry FIFO of classified ticks between front and back.
// Depends on i2cmbe_pkg.
module i2cmbe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cmbe_pkg::item_t   push_item,
  output logic                full,
  input  logic                pop,
  output i2cmbe_pkg::q_head_t head
);
  import i2cmbe_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/i2cmbe_back.sv */
// Back end: phase sequencer, shift register and result register.
// Depends on i2cmbe_pkg; fed by i2cmbe_queue.
module i2cmbe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          phase_ticks,
  input  i2cmbe_pkg::q_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_scl_out,
  output logic                out_sda_out,
  output logic                out_busy_res,
  output logic                out_done_res,
  output logic [i2cmbe_pkg::DATA_BITS-1:0] out_rx_byte,
  output logic                out_ack_seen
);
  import i2cmbe_pkg::*;

  logic [4:0]           step_r, step_nxt;
  op_t                  op_r, op_nxt;
  logic [3:0]           bc_r, bc_nxt;
  logic [DATA_BITS-1:0] sh_r, sh_nxt;
  logic [7:0]           pc_r, pc_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 ack_r, ack_nxt;
  logic                 ats_r, ats_nxt;
  logic [DATA_BITS-1:0] rx_r, rx_nxt;
  logic                 done_r, done_nxt;
  logic                 ovld_r, ovld_nxt;

  logic [4:0] p;
  logic [5:0] m_end;
  logic [1:0] lv;
  logic [3:0] bc_inc;
  logic [DATA_BITS-1:0] sh_rd;

  // phase within a send bit: p - 3*bit_count (bit_count equals p/3)
  function automatic logic [5:0] sub_phase(logic [4:0] pp, logic [3:0] bc);
    logic [5:0] t;
    begin
      t = {1'b0, bc, 1'b0} + {2'b00, bc};
      return {1'b0, pp} - t;
    end
  endfunction

  // pin levels {scl, sda} for phase pp
  function automatic logic [1:0] phase_levels(op_t op, logic [4:0] pp,
                                              logic [DATA_BITS-1:0] sh,
                                              logic [3:0] bc, logic ats,
                                              logic scl_cur);
    logic [5:0] m;
    logic       s;
    logic       d;
    begin
      m = sub_phase(pp, bc);
      s = scl_cur;
      d = 1'b1;
      unique case (op)
        OP_START: begin
          s = (pp < 5'd2);
          d = (pp == 5'd0);
        end
        OP_STOP: begin
          s = 1'b1;
          d = 1'b0;
        end
        OP_SEND: begin
          s = (m == 6'd1);
          d = (m == 6'd2 && bc == LAST_BIT) ? 1'b1 : sh[DATA_BITS-1];
        end
        OP_WAIT: begin
          if (pp != 5'd0) begin
            s = (pp == 5'd1);
          end
          d = 1'b1;
        end
        default: begin
          if (pp < PH_RBITS) begin
            s = ~pp[0];
            d = 1'b1;
          end else begin
            s = (pp == PH_RBITS + 5'd1);
            d = ~ats;
          end
        end
      endcase
      return {s, d};
    end
  endfunction

  assign pop       = head.valid & (~ovld_r | ~out_stall);
  assign p         = step_r - 5'd1;
  assign m_end     = sub_phase(p, bc_r);
  assign bc_inc    = bc_r + 4'd1;
  assign sh_rd     = {sh_r[DATA_BITS-2:0], head.item.sda_in};

  always_comb begin
    step_nxt = step_r;
    op_nxt   = op_r;
    bc_nxt   = bc_r;
    sh_nxt   = sh_r;
    pc_nxt   = pc_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    ack_nxt  = ack_r;
    ats_nxt  = ats_r;
    rx_nxt   = rx_r;
    done_nxt = 1'b0;
    lv       = 2'b11;
    if (step_r == 5'd0) begin
      if (head.item.cmd_go) begin
        op_nxt   = head.item.op;
        step_nxt = 5'd1;
        pc_nxt   = 8'd1;
        bc_nxt   = 4'd0;
        if (head.item.op == OP_SEND) begin
          sh_nxt = head.item.tx_byte;
        end else if (head.item.op == OP_READ) begin
          sh_nxt  = '0;
          ats_nxt = head.item.send_ack;
        end
        lv = phase_levels(op_nxt, 5'd0, sh_nxt, 4'd0, ats_nxt, scl_r);
        scl_nxt = lv[1];
        sda_nxt = lv[0];
      end
    end else if (pc_r >= phase_ticks) begin
      // end of phase: sample / shift
      unique case (op_r)
        OP_SEND: begin
          if (m_end == 6'd2) begin
            sh_nxt = {sh_r[DATA_BITS-2:0], 1'b0};
            bc_nxt = bc_inc;
          end
        end
        OP_WAIT: begin
          if (p == 5'd1) begin
            ack_nxt = head.item.sda_in;
          end
        end
        OP_READ: begin
          if (p < PH_RBITS && !p[0]) begin
            sh_nxt = sh_rd;
            bc_nxt = bc_inc;
            if (bc_inc == BYTE_BITS) begin
              rx_nxt = sh_rd;
            end
          end
        end
        default: begin
        end
      endcase
      if (step_r >= total_phases(op_r)) begin
        if (op_r != OP_START) begin
          sda_nxt = 1'b1;
          if (op_r != OP_STOP) begin
            scl_nxt = 1'b0;
          end
        end
        step_nxt = 5'd0;
        pc_nxt   = 8'd0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 5'd1;
        pc_nxt   = 8'd1;
        lv = phase_levels(op_r, step_r, sh_nxt, bc_nxt, ats_r, scl_r);
        scl_nxt = lv[1];
        sda_nxt = lv[0];
      end
    end else begin
      pc_nxt = pc_r + 8'd1;
    end
  end

  assign ovld_nxt = pop ? 1'b1 : (ovld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      op_r   <= OP_START;
      bc_r   <= '0;
      sh_r   <= '0;
      pc_r   <= '0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
      ack_r  <= 1'b0;
      ats_r  <= 1'b0;
      rx_r   <= '0;
      done_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
      if (pop) begin
        step_r <= step_nxt;
        op_r   <= op_nxt;
        bc_r   <= bc_nxt;
        sh_r   <= sh_nxt;
        pc_r   <= pc_nxt;
        scl_r  <= scl_nxt;
        sda_r  <= sda_nxt;
        ack_r  <= ack_nxt;
        ats_r  <= ats_nxt;
        rx_r   <= rx_nxt;
        done_r <= done_nxt;
      end
    end
  end

  // state only moves on a pop, so it doubles as the result register
  assign out_valid    = ovld_r;
  assign out_scl_out  = scl_r;
  assign out_sda_out  = sda_r;
  assign out_busy_res = (step_r != 5'd0);
  assign out_done_res = done_r;
  assign out_rx_byte  = rx_r;
  assign out_ack_seen = ack_r;

endmodule

/* bench/i2c_pin_checker.sv */
// Scoreboard for the I2C master bit engine: tracks accepted requests, predicts
// each tick's pin/status result and compares it with the result channel.
// Depends on i2cmbe_pkg for DATA_BITS, PHASE_TICKS_RST and the opcode enum.
module i2c_pin_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_cmd_valid,
  input  logic [2:0]           in_opcode,
  input  logic [i2cmbe_pkg::DATA_BITS-1:0] in_tx_byte,
  input  logic                 in_send_ack,
  input  logic                 in_sda_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_scl_out,
  input  logic                 out_sda_out,
  input  logic                 out_busy_res,
  input  logic                 out_done_res,
  input  logic [i2cmbe_pkg::DATA_BITS-1:0] out_rx_byte,
  input  logic                 out_ack_seen,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  output int                   fail_count,
  output int                   pending_results
);
  import i2cmbe_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                 scl;
    logic                 sda;
    logic                 busy;
    logic                 done;
    logic [DATA_BITS-1:0] rx;
    logic                 ack;
  } pin_status_t;

  pin_status_t expected_pins[$];

  // engine mirror
  logic [7:0]           tick_limit;
  logic [4:0]           step;
  op_t                  cur_op;
  logic [3:0]           nbits;
  logic [DATA_BITS-1:0] shreg;
  logic [7:0]           ph_cnt;
  logic                 scl_lvl;
  logic                 sda_lvl;
  logic                 ack_flag;
  logic                 ack_out;
  logic [DATA_BITS-1:0] rx_last;
  int                   fails = 0;

  function automatic int phases_in(op_t o);
    case (o)
      OP_START: return 3;
      OP_STOP:  return 1;
      OP_SEND:  return 3 * DATA_BITS;
      OP_WAIT:  return 3;
      default:  return 2 * DATA_BITS + 3;
    endcase
  endfunction

  // pin levels for the phase that just opened
  task automatic set_levels;
    logic [4:0] p;
    p = step - 5'd1;
    case (cur_op)
      OP_START: begin
        scl_lvl = (p < 2);
        sda_lvl = (p == 0);
      end
      OP_STOP: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b0;
      end
      OP_SEND: begin
        scl_lvl = (p % 3 == 1);
        // release SDA in the tail of the last bit
        sda_lvl = (p % 3 == 2 && p / 3 == DATA_BITS - 1) ? 1'b1 : shreg[DATA_BITS-1];
      end
      OP_WAIT: begin
        if (p != 0) scl_lvl = (p == 1);
        sda_lvl = 1'b1;
      end
      default: begin
        if (p < 2 * DATA_BITS) begin
          scl_lvl = (p % 2 == 0);
          sda_lvl = 1'b1;
        end else begin
          scl_lvl = (p == 2 * DATA_BITS + 1);
          sda_lvl = !ack_out;
        end
      end
    endcase
  endtask

  task automatic step_engine(input logic cv, input logic [2:0] opc,
                             input logic [DATA_BITS-1:0] txb, input logic sack,
                             input logic sda_s, output pin_status_t res);
    logic [4:0] p;
    logic       fin;
    fin = 1'b0;
    p = step - 5'd1;
    if (step == 5'd0) begin
      if (cv && opc <= OP_READ) begin
        cur_op = op_t'(opc);
        step = 5'd1;
        ph_cnt = 8'd1;
        nbits = 4'd0;
        if (cur_op == OP_SEND) begin
          shreg = txb;
        end else if (cur_op == OP_READ) begin
          shreg = '0;
          ack_out = sack;
        end
        set_levels();
      end
    end else if (ph_cnt >= tick_limit) begin
      case (cur_op)
        OP_SEND: begin
          if (p % 3 == 2) begin
            shreg = shreg << 1;
            nbits = nbits + 4'd1;
          end
        end
        OP_WAIT: begin
          if (p == 1) ack_flag = sda_s;
        end
        OP_READ: begin
          if (p < 2 * DATA_BITS && p % 2 == 0) begin
            shreg = {shreg[DATA_BITS-2:0], sda_s};
            nbits = nbits + 4'd1;
            if (nbits == DATA_BITS) rx_last = shreg;
          end
        end
        default: ;
      endcase
      if (step >= phases_in(cur_op)) begin
        if (cur_op != OP_START) begin
          sda_lvl = 1'b1;
          if (cur_op != OP_STOP) scl_lvl = 1'b0;
        end
        step = 5'd0;
        ph_cnt = 8'd0;
        fin = 1'b1;
      end else begin
        step = step + 5'd1;
        ph_cnt = 8'd1;
        set_levels();
      end
    end else begin
      ph_cnt = ph_cnt + 8'd1;
    end
    res.scl  = scl_lvl;
    res.sda  = sda_lvl;
    res.busy = (step != 5'd0);
    res.done = fin;
    res.rx   = rx_last;
    res.ack  = ack_flag;
  endtask

  always @(posedge clk) begin : watch
    pin_status_t want;
    pin_status_t got;
    if (!rst_n) begin
      tick_limit = PHASE_TICKS_RST;
      step = 5'd0;
      cur_op = OP_START;
      nbits = 4'd0;
      shreg = '0;
      ph_cnt = 8'd0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_flag = 1'b0;
      ack_out = 1'b0;
      rx_last = '0;
      expected_pins.delete();
    end else begin
      if (cfg_wr_en) tick_limit = cfg_wr_data;
      if (in_valid && !in_stall) begin
        step_engine(in_cmd_valid, in_opcode, in_tx_byte, in_send_ack, in_sda_in, want);
        expected_pins.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.scl  = out_scl_out;
        got.sda  = out_sda_out;
        got.busy = out_busy_res;
        got.done = out_done_res;
        got.rx   = out_rx_byte;
        got.ack  = out_ack_seen;
        if (expected_pins.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding: scl=%b sda=%b busy=%b",
                     $time, got.scl, got.sda, got.busy);
        end else begin
          want = expected_pins.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
              got.done !== want.done || got.rx !== want.rx || got.ack !== want.ack) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display({"%0t: mismatch exp scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                        " got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b"}, $time,
                       want.scl, want.sda, want.busy, want.done, want.rx, want.ack,
                       got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
          end
        end
      end
    end
    fail_count <= fails;
    pending_results <= expected_pins.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the I2C master bit engine: clock, reset, tick requests,
// result back-pressure, phase_ticks writes and the final verdict.
// Depends on i2cmbe_pkg, i2c_master_bit_engine_core and i2c_pin_checker.
module tb_top;
  import i2cmbe_pkg::*;

  // opcodes 5..7 carry no command; the engine must stay idle on them
  localparam logic [2:0] OP_IGNORED_FIRST = 3'd5;
  localparam logic [2:0] OP_IGNORED_LAST  = 3'd7;

  localparam int WATCHDOG_CYCLES = 4000;  // cycles without any handshake
  localparam int SQUEEZE_CYCLES  = 200;   // long receiver hold-off
  localparam int DRAIN_CYCLES    = 16;    // up to 3 requests in flight, plenty of margin
  localparam int RANDOM_SLICE    = 250;   // ticks per random stretch

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd_valid;
  logic [2:0]           in_opcode;
  logic [DATA_BITS-1:0] in_tx_byte;
  logic                 in_send_ack;
  logic                 in_sda_in;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_scl_out;
  logic                 out_sda_out;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [DATA_BITS-1:0] out_rx_byte;
  logic                 out_ack_seen;
  logic                 cfg_wr_en;
  logic [7:0]           cfg_wr_data;

  int         fail_count;
  int         pending_results;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         ticks_sent;
  logic [7:0] cur_ticks;    // phase_ticks as last written
  logic       squeeze_now;  // one-cycle pulse asking the receiver to hold off

  i2c_master_bit_engine_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd_valid (in_cmd_valid),
    .in_opcode    (in_opcode),
    .in_tx_byte   (in_tx_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_ack_seen (out_ack_seen),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  i2c_pin_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd_valid    (in_cmd_valid),
    .in_opcode       (in_opcode),
    .in_tx_byte      (in_tx_byte),
    .in_send_ack     (in_send_ack),
    .in_sda_in       (in_sda_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scl_out     (out_scl_out),
    .out_sda_out     (out_sda_out),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_ack_seen    (out_ack_seen),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Phase count of each command; the stimulus uses it to know how many
  // filler ticks keep the engine busy before the next command can land.
  function automatic int cmd_phases(logic [2:0] opc);
    case (opc)
      OP_START: return 3;
      OP_STOP:  return 1;
      OP_SEND:  return 3 * DATA_BITS;
      OP_WAIT:  return 3;
      OP_READ:  return 2 * DATA_BITS + 3;
      default:  return 0;
    endcase
  endfunction

  // SDA as seen on the bus: forced level when pick is 0/1, random when negative
  function automatic logic line_level(int pick);
    return (pick < 0) ? 1'($urandom_range(1)) : 1'(pick);
  endfunction

  // One timing tick request. Called at a falling edge, returns at a falling
  // edge right after acceptance with valid still high; the next caller either
  // replaces the payload or drops valid.
  task automatic push_tick(input logic cv, input logic [2:0] opc,
                           input logic [DATA_BITS-1:0] txb, input logic sack,
                           input logic sda);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd_valid <= cv;
    in_opcode    <= opc;
    in_tx_byte   <= txb;
    in_send_ack  <= sack;
    in_sda_in    <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Issue a command, then feed enough ticks to run it to completion.
  // Filler ticks carry random payload and now and then a command, which the
  // busy engine must drop; the last filler is the finishing tick, where a
  // command must be dropped as well.
  task automatic run_command(input logic [2:0] opc, input logic [DATA_BITS-1:0] txb,
                             input logic sack, input int sda_pick);
    int  fill;
    logic noise;
    fill = cmd_phases(opc) * ((cur_ticks == 8'd0) ? 1 : int'(cur_ticks));
    push_tick(1'b1, opc, txb, sack, line_level(sda_pick));
    for (int k = 1; k <= fill; k++) begin
      noise = ($urandom_range(7) == 0) || (k == fill && $urandom_range(1) == 1);
      push_tick(noise, 3'($urandom_range(7)), DATA_BITS'($urandom),
                1'($urandom_range(1)), line_level(sda_pick));
    end
    // occasional idle ticks with no command: bus levels must hold
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        push_tick(1'b0, 3'($urandom_range(7)), DATA_BITS'($urandom),
                  1'($urandom_range(1)), line_level(-1));
  endtask

  // A well-formed bus transfer: start, address byte, ack, up to two data bytes (send+ack or read), stop.
  task automatic run_transaction;
    int nbytes;
    nbytes = $urandom_range(2);
    run_command(OP_START, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
    run_command(OP_SEND, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
    run_command(OP_WAIT, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
    repeat (nbytes) begin
      if ($urandom_range(1) == 1) begin
        run_command(OP_SEND, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
        run_command(OP_WAIT, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
      end else begin
        run_command(OP_READ, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
      end
    end
    run_command(OP_STOP, DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
  endtask

  // Mostly full transfers; the rest are lone commands of any opcode, which
  // gives broken sequences (stop without start, reads out of place, junk ops).
  task automatic random_traffic(input int budget);
    int first;
    first = ticks_sent;
    while (ticks_sent - first < budget) begin
      if ($urandom_range(4) != 0)
        run_transaction();
      else
        run_command(3'($urandom_range(7)), DATA_BITS'($urandom),
                    1'($urandom_range(1)), -1);
    end
  endtask

  // phase_ticks may only change with the engine idle: every result back,
  // then a few cycles of margin before the write.
  task automatic load_phase_ticks(input logic [7:0] v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_ticks = v;
  endtask

  // Pulse the receiver into a long hold-off; valid drops for this cycle so
  // the last request is not offered twice.
  task automatic squeeze_receiver;
    in_valid    <= 1'b0;
    squeeze_now <= 1'b1;
    @(negedge clk);
    squeeze_now <= 1'b0;
  endtask

  // Result side: random stall per cycle, or a long counted hold-off on request.
  // squeeze_now is read at the falling edge before the stimulus updates it.
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_now) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any handshake on either channel ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("i2c_master_bit_engine_core test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd_valid  = 1'b0;
    in_opcode     = OP_START;
    in_tx_byte    = '0;
    in_send_ack   = 1'b0;
    in_sda_in     = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    squeeze_now   = 1'b0;
    ticks_sent    = 0;
    cur_ticks     = PHASE_TICKS_RST;
    send_idle_pct = 37;
    recv_idle_pct = 60;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: one tick per phase, every command and corner ----
    load_phase_ticks(8'd1);
    run_command(OP_START, 8'h00, 1'b0, -1);
    run_command(OP_SEND, 8'h00, 1'b0, -1);
    run_command(OP_WAIT, 8'h00, 1'b0, 0);          // slave acknowledges
    run_command(OP_SEND, 8'hFF, 1'b1, -1);
    run_command(OP_WAIT, 8'hFF, 1'b1, 1);          // no acknowledge
    run_command(OP_READ, 8'h00, 1'b1, 1);          // all ones, then ACK
    run_command(OP_READ, 8'hFF, 1'b0, 0);          // all zeros, then NACK
    run_command(OP_STOP, 8'h00, 1'b0, -1);         // stop with SCL low
    run_command(OP_STOP, 8'hFF, 1'b1, -1);         // stop on a released bus
    for (int c = OP_IGNORED_FIRST; c <= OP_IGNORED_LAST; c++)
      run_command(3'(c), DATA_BITS'($urandom), 1'($urandom_range(1)), -1);
    push_tick(1'b0, OP_READ, 8'hA5, 1'b1, 1'b0);   // idle tick, no command
    run_command(OP_WAIT, 8'h5A, 1'b0, -1);         // wait ack from SCL high
    run_command(OP_READ, 8'h3C, 1'b1, -1);

    // zero phase length behaves as one
    load_phase_ticks(8'd0);
    run_command(OP_START, 8'h00, 1'b0, -1);
    run_command(OP_SEND, DATA_BITS'($urandom), 1'b0, -1);
    run_command(OP_STOP, 8'h00, 1'b0, -1);

    // longest phase: only the one-phase stop and an ignored opcode
    load_phase_ticks(8'd255);
    run_command(OP_STOP, 8'h00, 1'b0, -1);
    run_command(OP_IGNORED_LAST, 8'hFF, 1'b1, -1);

    // ---- random, sender idles less than receiver ----
    load_phase_ticks(8'd3);
    squeeze_receiver();
    random_traffic(RANDOM_SLICE);

    // ---- random, receiver idles less than sender ----
    load_phase_ticks(8'd2);
    send_idle_pct = 60;
    recv_idle_pct = 37;
    random_traffic(RANDOM_SLICE);

    // ---- random, both sides at full rate; the hold-off must back up the
    // request queue and raise in_stall ----
    load_phase_ticks(8'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    squeeze_receiver();
    random_traffic(RANDOM_SLICE);

    // drain: every result back, then a few quiet cycles for stray results
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_results == 0)
      $display("i2c_master_bit_engine_core test passed");
    else
      $display("i2c_master_bit_engine_core test failed");
    $finish;
  end

endmodule
